// ===== src/ppt_pkg.sv =====
// ppt_pkg: shared types, codes and constants of the peer pairing table
// used by every module under src, no dependencies

package ppt_pkg;

  localparam int unsigned MAX_NODES_DEF = 16;
  localparam int unsigned MAX_RESULTS   = 16;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QUEUE_PTR_W   = 1;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [15:0] TIMEOUT_RST = 16'd5000;
  localparam logic [7:0]  VERSION_RST = 8'd1;

  // register index taken from paddr[2]
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_VERSION = 1'b1;

  localparam logic [31:0] CAM_TAG  = 32'h43616D2D;   // "Cam-"
  localparam logic [39:0] SENS_TAG = 40'h53656E732D; // "Sens-"

  typedef enum logic [2:0] {
    KIND_ADV    = 3'd0,
    KIND_KEEP   = 3'd1,
    KIND_PAIR   = 3'd2,
    KIND_UNPAIR = 3'd3,
    KIND_LIST   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    STS_DONE      = 3'd0,
    STS_IGNORED   = 3'd1,
    STS_FULL      = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_REFUSED   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CLS_UNKNOWN = 2'd0,
    CLS_CAMERA  = 2'd1,
    CLS_SENSOR  = 2'd2
  } class_e;

  typedef enum logic [2:0] {
    OP_IGNORE,
    OP_ADV,
    OP_KEEP,
    OP_PAIR,
    OP_UNPAIR,
    OP_LIST
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ACT,
    ST_LRD,
    ST_LCHK,
    ST_LEND
  } state_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [47:0] dev_addr;
    logic [7:0]  msg_version;
    logic        length_ok;
    logic [39:0] name_prefix;
    logic [31:0] now_ms;
    logic [1:0]  query_class;
    logic [4:0]  max_count;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        send_adv_ack;
    logic        send_set_time;
    logic        send_pair_request;
    logic        send_unpair;
    logic        entry_valid;
    logic [47:0] entry_addr;
    logic [1:0]  entry_class;
    logic        entry_paired;
    logic [31:0] entry_last_seen;
    logic        last;
  } out_t;

  // classified event as queued between front and back
  typedef struct packed {
    op_e         op;
    logic [47:0] addr;
    logic [1:0]  cls;
    logic [31:0] now;
    logic [1:0]  qclass;
    logic [4:0]  maxc;
  } cmd_t;

  typedef struct packed {
    logic [47:0] addr;
    logic [1:0]  cls;
    logic [31:0] seen;
  } entry_t;

  function automatic logic [1:0] class_of(input logic [39:0] prefix);
    logic [1:0] c;
    c = CLS_UNKNOWN;
    if (prefix[39:8] == CAM_TAG) begin
      c = CLS_CAMERA;
    end else if (prefix == SENS_TAG) begin
      c = CLS_SENSOR;
    end
    return c;
  endfunction

endpackage

// ===== src/ppt_front.sv =====
// ppt_front: accepts events and classifies them into queue commands
// depends on ppt_pkg

module ppt_front import ppt_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_data_i,
  input  logic [7:0] version_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output cmd_t       q_cmd_o
);

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_cmd_o.addr   = in_data_i.dev_addr;
    q_cmd_o.cls    = class_of(in_data_i.name_prefix);
    q_cmd_o.now    = in_data_i.now_ms;
    q_cmd_o.qclass = in_data_i.query_class;
    q_cmd_o.maxc   = (in_data_i.max_count > 5'(MAX_RESULTS)) ? 5'(MAX_RESULTS)
                                                             : in_data_i.max_count;
    unique case (in_data_i.kind)
      KIND_ADV: begin
        if (!in_data_i.length_ok || in_data_i.msg_version != version_i) begin
          q_cmd_o.op = OP_IGNORE;
        end else begin
          q_cmd_o.op = OP_ADV;
        end
      end
      KIND_KEEP:   q_cmd_o.op = in_data_i.length_ok ? OP_KEEP : OP_IGNORE;
      KIND_PAIR:   q_cmd_o.op = OP_PAIR;
      KIND_UNPAIR: q_cmd_o.op = OP_UNPAIR;
      KIND_LIST:   q_cmd_o.op = OP_LIST;
      default:     q_cmd_o.op = OP_IGNORE;
    endcase
  end

endmodule

// ===== src/ppt_fifo.sv =====
// ppt_fifo: short command queue between the front and the back
// depends on ppt_pkg

module ppt_fifo import ppt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  cmd_t                   slot_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QUEUE_PTR_W:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ===== src/ppt_back.sv =====
// ppt_back: table sequencer, scans the entry memory, applies updates
// and drives the result register; depends on ppt_pkg

module ppt_back import ppt_pkg::*; #(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] timeout_i,
  input  logic        q_empty_i,
  input  cmd_t        q_cmd_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o
);

  localparam int unsigned IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CW = $clog2(MAX_NODES + 1);

  entry_t mem [MAX_NODES];
  entry_t rdata_q;
  logic [IW-1:0] rd_idx;
  logic          mem_we;
  logic [IW-1:0] mem_widx;
  entry_t        mem_wdata;

  state_e state_q, state_d;
  cmd_t   cur_q, cur_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [IW-1:0] pidx_q, pidx_d;
  logic          pend_q, pend_d;
  logic          hit_q, hit_d;
  logic [IW-1:0] hit_idx_q, hit_idx_d;
  entry_t        ent_q, ent_d;
  logic [4:0]    n_q, n_d;
  logic          hold_v_q, hold_v_d;
  out_t          hold_q, hold_d;
  logic [MAX_NODES-1:0] paired_q, paired_d, blocked_q, blocked_d;
  logic   out_valid_q, out_valid_d;
  out_t   out_q, out_d;

  logic   slot_free;
  logic   match;
  logic   pass;
  logic [31:0] age;
  out_t   res;
  out_t   cand;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign match       = pend_q && (rdata_q.addr == cur_q.addr);
  assign age         = cur_q.now - rdata_q.seen;
  assign pass        = ((cur_q.qclass == 2'd0) || (rdata_q.cls == cur_q.qclass)) &&
                       (age <= {16'd0, timeout_i});
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    cand                 = '0;
    cand.entry_valid     = 1'b1;
    cand.entry_addr      = rdata_q.addr;
    cand.entry_class     = rdata_q.cls;
    cand.entry_paired    = paired_q[pidx_q];
    cand.entry_last_seen = rdata_q.seen;
  end

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pidx_d      = pidx_q;
    pend_d      = 1'b0;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    ent_d       = ent_q;
    n_d         = n_q;
    hold_v_d    = hold_v_q;
    hold_d      = hold_q;
    paired_d    = paired_q;
    blocked_d   = blocked_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    q_pop_o     = 1'b0;
    rd_idx      = pidx_q;
    mem_we      = 1'b0;
    mem_widx    = hit_idx_q;
    mem_wdata   = '0;
    res         = '0;
    res.last    = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o  = 1'b1;
          cur_d    = q_cmd_i;
          idx_d    = '0;
          n_d      = '0;
          hold_v_d = 1'b0;
          if (q_cmd_i.op == OP_IGNORE) begin
            state_d = ST_ACT;
          end else if (q_cmd_i.op == OP_LIST) begin
            state_d = ST_LRD;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      // reads issue one a cycle, each compare follows in the cycle after its read
      ST_SCAN: begin
        if (match) begin
          hit_d     = 1'b1;
          hit_idx_d = pidx_q;
          ent_d     = rdata_q;
          state_d   = ST_ACT;
        end else if (idx_q < count_q) begin
          rd_idx = idx_q[IW-1:0];
          pidx_d = idx_q[IW-1:0];
          idx_d  = idx_q + 1'b1;
          pend_d = 1'b1;
        end else begin
          hit_d   = 1'b0;
          state_d = ST_ACT;
        end
      end

      ST_ACT: begin
        if (slot_free) begin
          case (cur_q.op)
            OP_ADV: begin
              mem_wdata = '{addr: cur_q.addr, cls: cur_q.cls, seen: cur_q.now};
              if (hit_q) begin
                mem_we           = 1'b1;
                res.send_adv_ack = 1'b1;
              end else if (count_q == CW'(MAX_NODES)) begin
                res.status = STS_FULL;
              end else begin
                mem_we           = 1'b1;
                mem_widx         = count_q[IW-1:0];
                count_d          = count_q + 1'b1;
                res.send_adv_ack = 1'b1;
              end
            end
            OP_KEEP: begin
              if (!hit_q) begin
                res.status = STS_NOT_FOUND;
              end else begin
                mem_we    = 1'b1;
                mem_wdata = '{addr: ent_q.addr, cls: ent_q.cls, seen: cur_q.now};
                if (!blocked_q[hit_idx_q]) begin
                  res.send_set_time   = !paired_q[hit_idx_q];
                  paired_d[hit_idx_q] = 1'b1;
                end
              end
            end
            OP_PAIR: begin
              if (!hit_q) begin
                res.status = STS_NOT_FOUND;
              end else if (paired_q[hit_idx_q]) begin
                res.status = STS_REFUSED;
              end else begin
                blocked_d[hit_idx_q]  = 1'b0;
                res.send_pair_request = 1'b1;
              end
            end
            OP_UNPAIR: begin
              if (!hit_q) begin
                res.status = STS_NOT_FOUND;
              end else begin
                paired_d[hit_idx_q]  = 1'b0;
                blocked_d[hit_idx_q] = 1'b1;
                res.send_unpair      = 1'b1;
              end
            end
            default: res.status = STS_IGNORED;
          endcase
          out_valid_d = 1'b1;
          out_d       = res;
          state_d     = ST_IDLE;
        end
      end

      ST_LRD: begin
        if ((n_q >= cur_q.maxc) || (idx_q >= count_q)) begin
          state_d = ST_LEND;
        end else begin
          rd_idx  = idx_q[IW-1:0];
          pidx_d  = idx_q[IW-1:0];
          idx_d   = idx_q + 1'b1;
          state_d = ST_LCHK;
        end
      end

      // the newest passing entry is held back until it is known whether it is last
      ST_LCHK: begin
        if (!pass) begin
          state_d = ST_LRD;
        end else if (!hold_v_q) begin
          hold_d   = cand;
          hold_v_d = 1'b1;
          n_d      = n_q + 1'b1;
          state_d  = ST_LRD;
        end else if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = hold_q;
          out_d.last  = 1'b0;
          hold_d      = cand;
          n_d         = n_q + 1'b1;
          state_d     = ST_LRD;
        end
      end

      ST_LEND: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          if (hold_v_q) begin
            out_d      = hold_q;
            out_d.last = 1'b1;
          end else begin
            out_d = res;
          end
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      hold_v_q    <= 1'b0;
      paired_q    <= '0;
      blocked_q   <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      n_q         <= '0;
      hit_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      hold_v_q    <= hold_v_d;
      paired_q    <= paired_d;
      blocked_q   <= blocked_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      hit_q       <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    pidx_q    <= pidx_d;
    hit_idx_q <= hit_idx_d;
    ent_q     <= ent_d;
    hold_q    <= hold_d;
    out_q     <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_widx] <= mem_wdata;
    end
    rdata_q <= mem[rd_idx];
  end

endmodule

// ===== src/peer_pairing_table_core.sv =====
// peer_pairing_table_core: the back end handles one event at a time and
// walks the entries through the single read port of the entry memory for
// lookups and list queries; the queue takes further events meanwhile.
// Reset clears the entry count, paired and blocked flags and the queue; the
// entry memory is left as is and needs no clearing pass.

module peer_pairing_table_core import ppt_pkg::*; #(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [15:0] timeout_q;
  logic [7:0]  version_q;
  logic        cfg_wr;

  logic q_full, q_push, q_empty, q_pop;
  cmd_t q_in, q_out;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
      version_q <= VERSION_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_TIMEOUT: timeout_q <= pwdata[15:0];
        REG_VERSION: version_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TIMEOUT: prdata = {16'd0, timeout_q};
      REG_VERSION: prdata = {24'd0, version_q};
      default:     prdata = '0;
    endcase
  end

  ppt_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .version_i  (version_q),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_in)
  );

  ppt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (q_out)
  );

  ppt_back #(
    .MAX_NODES (MAX_NODES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .timeout_i   (timeout_q),
    .q_empty_i   (q_empty),
    .q_cmd_i     (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
